// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks are clocked on i_clk and held off while i_rst_n is low.
`define IMUCAL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`define IMUCAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/imucal_pkg.sv =====
`timescale 1ns / 1ps

package imucal_pkg;

    localparam int RAW_W  = 16;
    localparam int FRAC_W = 4;
    localparam int SUM_W  = 26;
    localparam int OFF_W  = 21;
    localparam int CNT_W  = 9;
    localparam int G_W    = 15;
    localparam int APB_W  = 32;
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 192;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_ONE_G = 1'b0;

    localparam logic [G_W-1:0] ONE_G_RESET = 15'd4096;

    typedef logic signed [RAW_W-1:0] t_raw;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [OFF_W-1:0] t_off;

    localparam t_off OUT_MAX = {1'b0, {(OFF_W-1){1'b1}}};
    localparam t_off OUT_MIN = {1'b1, {(OFF_W-1){1'b0}}};

    typedef struct packed {
        logic       start;
        t_raw [2:0] mag;
        t_raw [2:0] gyr;
        t_raw [2:0] acc;
    } t_item;

    typedef struct packed {
        t_item      item;
        logic       active;
        logic       done;
        t_sum [2:0] acc_sum;
        t_sum [2:0] gyr_sum;
        t_off [2:0] mag_off;
    } t_acc_st;

    typedef struct packed {
        t_item      item;
        logic       active;
        logic       done;
        t_off [2:0] acc_off;
        t_off [2:0] gyr_off;
        t_off [2:0] mag_off;
    } t_div_st;

    typedef struct packed {
        logic       done;
        logic       active;
        t_off [8:0] axis;
    } t_res;

endpackage

// ===== design/imucal_accum.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imucal_accum #(
    parameter int CAL_SAMPLES = 300
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [imucal_pkg::G_W-1:0]    i_one_g,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  imucal_pkg::t_item             i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output imucal_pkg::t_acc_st           o_st
);

    localparam int RAW_W = imucal_pkg::RAW_W;
    localparam int SUM_W = imucal_pkg::SUM_W;
    localparam int CNT_W = imucal_pkg::CNT_W;
    localparam int G_W   = imucal_pkg::G_W;

    logic                     r_v;
    imucal_pkg::t_acc_st      r_st;
    imucal_pkg::t_sum [2:0]   r_acc_sum, n_acc_sum;
    imucal_pkg::t_sum [2:0]   r_gyr_sum, n_gyr_sum;
    imucal_pkg::t_raw [2:0]   r_max, n_max;
    imucal_pkg::t_raw [2:0]   r_min, n_min;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_active, n_active, n_done;
    logic                     fire;
    logic [2:0][RAW_W:0]      acc_in;
    logic [2:0][RAW_W:0]      mag_mid;

    assign o_ready = !r_v || i_ready;
    assign fire    = i_valid && o_ready;
    assign o_valid = r_v;
    assign o_st    = r_st;

    always_comb begin
        acc_in[0] = {i_item.acc[0][RAW_W-1], i_item.acc[0]};
        acc_in[1] = {i_item.acc[1][RAW_W-1], i_item.acc[1]};
        acc_in[2] = {i_item.acc[2][RAW_W-1], i_item.acc[2]}
                  - {{(RAW_W+1-G_W){1'b0}}, i_one_g};

        n_acc_sum = r_acc_sum;
        n_gyr_sum = r_gyr_sum;
        n_max     = r_max;
        n_min     = r_min;
        n_cnt     = r_cnt;
        n_active  = r_active;
        n_done    = 1'b0;

        if (i_item.start) begin
            n_acc_sum = '0;
            n_gyr_sum = '0;
            n_max     = '0;
            n_min     = '0;
            n_cnt     = '0;
            n_active  = 1'b1;
        end else if (r_active) begin
            for (int i = 0; i < 3; i++) begin
                n_acc_sum[i] = r_acc_sum[i]
                             + {{(SUM_W-RAW_W-1){acc_in[i][RAW_W]}}, acc_in[i]};
                n_gyr_sum[i] = r_gyr_sum[i]
                             + {{(SUM_W-RAW_W){i_item.gyr[i][RAW_W-1]}}, i_item.gyr[i]};
                if (r_cnt == '0) begin
                    n_max[i] = i_item.mag[i];
                    n_min[i] = i_item.mag[i];
                end else begin
                    if ($signed(i_item.mag[i]) > $signed(r_max[i])) n_max[i] = i_item.mag[i];
                    if ($signed(i_item.mag[i]) < $signed(r_min[i])) n_min[i] = i_item.mag[i];
                end
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (n_cnt >= CNT_W'(CAL_SAMPLES)) begin
                n_active = 1'b0;
                n_done   = 1'b1;
            end
        end

        for (int i = 0; i < 3; i++) begin
            mag_mid[i] = {n_max[i][RAW_W-1], n_max[i]} + {n_min[i][RAW_W-1], n_min[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= 1'b0;
            r_acc_sum <= '0;
            r_gyr_sum <= '0;
            r_max     <= '0;
            r_min     <= '0;
            r_cnt     <= '0;
            r_active  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v <= i_valid;
            end
            if (fire) begin
                r_acc_sum <= n_acc_sum;
                r_gyr_sum <= n_gyr_sum;
                r_max     <= n_max;
                r_min     <= n_min;
                r_cnt     <= n_cnt;
                r_active  <= n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_st.item    <= i_item;
            r_st.active  <= n_active;
            r_st.done    <= n_done;
            r_st.acc_sum <= n_acc_sum;
            r_st.gyr_sum <= n_gyr_sum;
            for (int i = 0; i < 3; i++) begin
                // midpoint times 16 is (max + min) * 8
                r_st.mag_off[i] <= {mag_mid[i][RAW_W], mag_mid[i], 3'b000};
            end
        end
    end

    `IMUCAL_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(CAL_SAMPLES), "sample count past run length")
    `IMUCAL_ASSERT_NEXT(a_done_ends_run, fire && n_done,
        (r_cnt == CNT_W'(CAL_SAMPLES)) && !r_active, "run did not close on completion")

endmodule

// ===== design/imucal_div.sv =====
`timescale 1ns / 1ps

module imucal_div #(
    parameter int CAL_SAMPLES = 300
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  imucal_pkg::t_acc_st  i_st,
    output logic                 o_valid,
    input  logic                 i_ready,
    output imucal_pkg::t_div_st  o_st
);

    localparam int SUM_W = imucal_pkg::SUM_W;
    localparam int OFF_W = imucal_pkg::OFF_W;
    localparam int UW    = SUM_W + imucal_pkg::FRAC_W;
    localparam int NW    = UW + 1;
    localparam int MW    = UW + 1;
    localparam int L     = $clog2(CAL_SAMPLES);
    localparam int SH    = UW + L;
    localparam int LANES = 6;

    localparam logic [63:0]   RECIP_FULL = (64'd1 << SH) / 64'(CAL_SAMPLES);
    localparam logic [MW-1:0] RECIP      = RECIP_FULL[MW-1:0];
    localparam logic [NW-1:0] HALF       = NW'(CAL_SAMPLES / 2);
    localparam logic [NW-1:0] DIV_N      = NW'(CAL_SAMPLES);
    localparam logic [UW-1:0] DIV_U      = UW'(CAL_SAMPLES);

    imucal_pkg::t_sum [LANES-1:0]   lane_sum;
    logic [LANES-1:0][NW-1:0]       a_num;
    logic [LANES-1:0]               a_neg;
    logic [LANES-1:0][UW-1:0]       a_u;
    logic [LANES-1:0][UW+MW-1:0]    a_prod;
    logic [LANES-1:0][OFF_W-1:0]    a_q0;

    logic                           r_v3, r_v4, rdy3, rdy4;
    imucal_pkg::t_item              r3_item;
    logic                           r3_active, r3_done;
    imucal_pkg::t_off [2:0]         r3_mag_off;
    logic [LANES-1:0][OFF_W-1:0]    r_q0;
    logic [LANES-1:0][UW-1:0]       r_u;
    logic [LANES-1:0]               r_neg;

    logic [LANES-1:0][UW-1:0]       b_qn, b_rem;
    logic [LANES-1:0][OFF_W-1:0]    b_q, b_off;

    imucal_pkg::t_div_st            r_st4;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign o_ready = rdy3;
    assign o_valid = r_v4;
    assign o_st    = r_st4;

    assign lane_sum = {i_st.gyr_sum, i_st.acc_sum};

    // floor((16*sum + n/2) / n) on the magnitude, sign put back after
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            a_num[k]  = {lane_sum[k][SUM_W-1], lane_sum[k], {imucal_pkg::FRAC_W{1'b0}}} + HALF;
            a_neg[k]  = a_num[k][NW-1];
            a_u[k]    = a_neg[k] ? UW'(~a_num[k] + DIV_N) : a_num[k][UW-1:0];
            a_prod[k] = a_u[k] * RECIP;
            a_q0[k]   = a_prod[k][SH +: OFF_W];
        end
    end

    // reciprocal estimate is low by at most one
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            b_qn[k]  = UW'(r_q0[k]) * DIV_U;
            b_rem[k] = r_u[k] - b_qn[k];
            b_q[k]   = r_q0[k] + OFF_W'(b_rem[k] >= DIV_U);
            b_off[k] = r_neg[k] ? (~b_q[k] + OFF_W'(1)) : b_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy3) r_v3 <= i_valid;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_item    <= i_st.item;
            r3_active  <= i_st.active;
            r3_done    <= i_st.done;
            r3_mag_off <= i_st.mag_off;
            r_q0       <= a_q0;
            r_u        <= a_u;
            r_neg      <= a_neg;
        end
        if (rdy4) begin
            r_st4.item    <= r3_item;
            r_st4.active  <= r3_active;
            r_st4.done    <= r3_done;
            r_st4.mag_off <= r3_mag_off;
            r_st4.acc_off <= b_off[2:0];
            r_st4.gyr_off <= b_off[5:3];
        end
    end

endmodule

// ===== design/imucal_corr.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imucal_corr (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  imucal_pkg::t_div_st  i_st,
    output logic                 o_valid,
    input  logic                 i_ready,
    output imucal_pkg::t_res     o_res
);

    localparam int RAW_W  = imucal_pkg::RAW_W;
    localparam int OFF_W  = imucal_pkg::OFF_W;
    localparam int FRAC_W = imucal_pkg::FRAC_W;

    logic                    r_v, adv;
    imucal_pkg::t_res        r_res;
    imucal_pkg::t_off [8:0]  r_off, n_off;
    imucal_pkg::t_raw [8:0]  raw9;
    imucal_pkg::t_off [8:0]  axis;

    function automatic imucal_pkg::t_off sat_sub(input imucal_pkg::t_raw raw,
                                                 input imucal_pkg::t_off off);
        logic [OFF_W:0] diff;
        diff = {{(OFF_W+1-RAW_W-FRAC_W){raw[RAW_W-1]}}, raw, {FRAC_W{1'b0}}}
             - {off[OFF_W-1], off};
        if (diff[OFF_W] != diff[OFF_W-1]) begin
            sat_sub = diff[OFF_W] ? imucal_pkg::OUT_MIN : imucal_pkg::OUT_MAX;
        end else begin
            sat_sub = diff[OFF_W-1:0];
        end
    endfunction

    assign o_ready = !r_v || i_ready;
    assign adv     = i_valid && o_ready;
    assign o_valid = r_v;
    assign o_res   = r_res;

    always_comb begin
        raw9 = {i_st.item.mag, i_st.item.gyr, i_st.item.acc};
        if (i_st.item.start) begin
            n_off = '0;
        end else if (i_st.done) begin
            n_off = {i_st.mag_off, i_st.gyr_off, i_st.acc_off};
        end else begin
            n_off = r_off;
        end
        for (int k = 0; k < 9; k++) begin
            axis[k] = sat_sub(raw9[k], n_off[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_off <= '0;
        end else begin
            if (o_ready) r_v <= i_valid;
            if (adv) r_off <= n_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_res.done   <= i_st.done;
            r_res.active <= i_st.active;
            r_res.axis   <= axis;
        end
    end

    `IMUCAL_ASSERT(a_done_not_active, !(r_v && r_res.done) || !r_res.active,
        "completion beat still flagged calibrating")
    `IMUCAL_ASSERT_NEXT(a_off_hold, !(adv && (i_st.item.start || i_st.done)), $stable(r_off),
        "offsets moved without start or completion")

endmodule

// ===== design/imu_offset_calibrator.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Signals                       Contents
// s_*       in   tvalid tready tdata tuser     one nine-axis sample or start beat
// m_*       out  tvalid tready tdata tuser     nine corrected axes and run flags
// apb       in   psel penable pwrite paddr ... one_g_counts at byte address 0
//
// One beat accepted per cycle while no stage downstream is stalled. A result passes
// through five register stages (input register, accumulate, reciprocal
// multiply, quotient correction, result). The two-stage reciprocal divide sets
// the pipeline depth.
// Synchronous active-low reset clears sums, extremes, offsets, count and
// sets one_g_counts to 4096. Each stage holds while the next is full.

module imu_offset_calibrator #(
    parameter int CAL_SAMPLES = 300
) (
    input  logic         i_clk,
    input  logic         i_rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // accel_x, accel_y, accel_z, gyro_x..z, mag_x..z
    input  logic [0:0]   s_tuser,   // op

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // acc_x..z_out, gyr_x..z_out, mag_x..z_out, 3 pad
    output logic [1:0]   m_tuser,   // calibrating, cal_done

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int RAW_W = imucal_pkg::RAW_W;
    localparam int G_W   = imucal_pkg::G_W;
    localparam int OUT_PAD = imucal_pkg::M_TDATA_W - 9 * imucal_pkg::OFF_W;

    logic [G_W-1:0]        r_one_g;
    logic                  r_v1, rdy2, v2, rdy4, v4, v5;
    logic                  rdy3_w;
    imucal_pkg::t_item     r_item1, in_item;
    imucal_pkg::t_acc_st   st2;
    imucal_pkg::t_div_st   st4;
    imucal_pkg::t_res      res;

    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr[2] == imucal_pkg::REG_ONE_G) begin
            prdata = {{(imucal_pkg::APB_W-G_W){1'b0}}, r_one_g};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_g <= imucal_pkg::ONE_G_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == imucal_pkg::REG_ONE_G) begin
            r_one_g <= pwdata[G_W-1:0];
        end
    end

    always_comb begin
        in_item.start = (s_tuser[0] == imucal_pkg::OP_START);
        in_item.acc   = s_tdata[3*RAW_W-1:0];
        in_item.gyr   = s_tdata[6*RAW_W-1:3*RAW_W];
        in_item.mag   = s_tdata[9*RAW_W-1:6*RAW_W];
    end

    assign s_tready = !r_v1 || rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_tready) begin
            r_v1 <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready) r_item1 <= in_item;
    end

    imucal_accum #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_one_g (r_one_g),
        .i_valid (r_v1),
        .o_ready (rdy2),
        .i_item  (r_item1),
        .o_valid (v2),
        .i_ready (rdy3_w),
        .o_st    (st2)
    );

    imucal_div #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .o_ready (rdy3_w),
        .i_st    (st2),
        .o_valid (v4),
        .i_ready (rdy4),
        .o_st    (st4)
    );

    imucal_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v4),
        .o_ready (rdy4),
        .i_st    (st4),
        .o_valid (v5),
        .i_ready (m_tready),
        .o_res   (res)
    );

    assign m_tvalid = v5;
    assign m_tdata  = {{OUT_PAD{1'b0}}, res.axis};
    assign m_tuser  = {res.done, res.active};

endmodule

// ===== bench/imu_offset_calibrator_tb.sv =====
`timescale 1ns / 1ps

module imu_offset_calibrator_tb;

    localparam int CAL_N       = 300;
    localparam int GAP_MAX     = 18;
    localparam int QUIET_LIMIT = 4000;
    localparam int BEAT_TARGET = 1600;
    localparam int G_W         = imucal_pkg::G_W;

    typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} t_idle_mode;

    typedef struct packed {
        logic                   op;
        imucal_pkg::t_raw [2:0] mag;
        imucal_pkg::t_raw [2:0] gyr;
        imucal_pkg::t_raw [2:0] acc;
    } t_imu_beat;

    typedef struct packed {
        logic                   done;
        logic                   calibrating;
        imucal_pkg::t_off [8:0] axis;
    } t_corrected;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata  = '0;    // accel_x..z, gyro_x..z, mag_x..z
    logic [0:0]   s_tuser  = imucal_pkg::OP_SAMPLE;   // op
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;          // acc_x..z_out, gyr_x..z_out, mag_x..z_out, pad
    logic [1:0]   m_tuser;          // calibrating, cal_done
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    imu_offset_calibrator #(.CAL_SAMPLES(CAL_N)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 i_clk = ~i_clk;

    // calibration state as the block should hold it
    logic [G_W-1:0] one_g = imucal_pkg::ONE_G_RESET;
    imucal_pkg::t_sum acc_sum[3];
    imucal_pkg::t_sum gyr_sum[3];
    imucal_pkg::t_raw mag_hi[3];
    imucal_pkg::t_raw mag_lo[3];
    imucal_pkg::t_off acc_off[3];
    imucal_pkg::t_off gyr_off[3];
    imucal_pkg::t_off mag_off[3];
    int   cal_count;
    logic cal_running = 1'b0;

    t_corrected pending[$];
    t_idle_mode src_idle = IDLE_NONE;
    t_idle_mode snk_idle = IDLE_NONE;
    int mismatches     = 0;
    int beats_sent     = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    int runs_completed = 0;
    int saturated_axes = 0;
    int quiet_cycles   = 0;
    string axis_label[9] = '{"acc_x", "acc_y", "acc_z", "gyr_x", "gyr_y", "gyr_z",
                             "mag_x", "mag_y", "mag_z"};

    function automatic void clear_run();
        for (int i = 0; i < 3; i++) begin
            acc_sum[i] = '0;
            gyr_sum[i] = '0;
            mag_hi[i]  = '0;
            mag_lo[i]  = '0;
            acc_off[i] = '0;
            gyr_off[i] = '0;
            mag_off[i] = '0;
        end
        cal_count = 0;
    endfunction

    initial clear_run();

    // sum*16/N, nearest, ties towards plus infinity
    function automatic imucal_pkg::t_off rounded_mean(imucal_pkg::t_sum s);
        longint num;
        longint q;
        num = longint'(s) * 16 + CAL_N / 2;
        q = num / CAL_N;
        if (num < 0 && q * CAL_N != num) q = q - 1;
        return imucal_pkg::t_off'(q);
    endfunction

    function automatic imucal_pkg::t_off clamp_axis(imucal_pkg::t_raw raw,
                                                    imucal_pkg::t_off off);
        longint v;
        v = longint'(raw) * 16 - longint'(off);
        if (v > longint'(imucal_pkg::OUT_MAX)) begin
            v = longint'(imucal_pkg::OUT_MAX);
            saturated_axes++;
        end
        if (v < longint'(imucal_pkg::OUT_MIN)) begin
            v = longint'(imucal_pkg::OUT_MIN);
            saturated_axes++;
        end
        return imucal_pkg::t_off'(v);
    endfunction

    function automatic t_corrected predict_corrected(t_imu_beat b);
        t_corrected r;
        imucal_pkg::t_raw a[3];
        imucal_pkg::t_raw g[3];
        imucal_pkg::t_raw m[3];
        logic signed [16:0] av;
        for (int i = 0; i < 3; i++) begin
            a[i] = b.acc[i];
            g[i] = b.gyr[i];
            m[i] = b.mag[i];
        end
        r.done = 1'b0;
        if (b.op == imucal_pkg::OP_START) begin
            clear_run();
            cal_running = 1'b1;
        end else if (cal_running) begin
            for (int i = 0; i < 3; i++) begin
                av = a[i];
                if (i == 2) av = a[i] - $signed({2'b00, one_g});
                acc_sum[i] = acc_sum[i] + av;
                gyr_sum[i] = gyr_sum[i] + g[i];
                if (cal_count == 0) begin
                    mag_hi[i] = m[i];
                    mag_lo[i] = m[i];
                end else begin
                    if (m[i] > mag_hi[i]) mag_hi[i] = m[i];
                    if (m[i] < mag_lo[i]) mag_lo[i] = m[i];
                end
            end
            cal_count++;
            if (cal_count >= CAL_N) begin
                for (int i = 0; i < 3; i++) begin
                    acc_off[i] = rounded_mean(acc_sum[i]);
                    gyr_off[i] = rounded_mean(gyr_sum[i]);
                    mag_off[i] = imucal_pkg::t_off'((int'(mag_hi[i]) + int'(mag_lo[i])) * 8);
                end
                cal_running = 1'b0;
                r.done = 1'b1;
                runs_completed++;
            end
        end
        for (int i = 0; i < 3; i++) begin
            r.axis[i]     = clamp_axis(a[i], acc_off[i]);
            r.axis[3 + i] = clamp_axis(g[i], gyr_off[i]);
            r.axis[6 + i] = clamp_axis(m[i], mag_off[i]);
        end
        r.calibrating = cal_running;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t mismatch at result %0d, %s: got %0d, expected %0d",
                     $realtime, results_seen, what, got, want);
    endtask

    task automatic check_result(t_corrected got);
        t_corrected want;
        if (pending.size() == 0) begin
            report_mismatch("result with nothing outstanding", 1, 0);
            return;
        end
        want = pending.pop_front();
        results_seen++;
        for (int i = 0; i < 9; i++)
            if (got.axis[i] !== want.axis[i])
                report_mismatch(axis_label[i], longint'($signed(got.axis[i])),
                                longint'($signed(want.axis[i])));
        if (got.calibrating !== want.calibrating)
            report_mismatch("calibrating", got.calibrating, want.calibrating);
        if (got.done !== want.done)
            report_mismatch("cal_done", got.done, want.done);
    endtask

    // beat monitor: register writes, results, then new beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                one_g = pwdata[G_W-1:0];
                reg_writes++;
            end
            if (m_tvalid && m_tready)
                check_result(t_corrected'({m_tuser[1], m_tuser[0], m_tdata[188:0]}));
            if (s_tvalid && s_tready)
                pending.push_back(predict_corrected(t_imu_beat'({s_tuser, s_tdata})));
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d cycles without a beat, %0d results outstanding",
                     quiet_cycles, pending.size());
            $display("imu_offset_calibrator verification failed");
            $finish;
        end
    end

    function automatic int draw_gap(t_idle_mode mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, GAP_MAX) : 0;
            default:   return $urandom_range(0, GAP_MAX);
        endcase
    endfunction

    // result side back-pressure
    initial begin
        int stall;
        @(posedge i_clk);
        forever begin
            stall = draw_gap(snk_idle);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    task automatic send_beat(input t_imu_beat b);
        int gap;
        gap = draw_gap(src_idle);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b.mag, b.gyr, b.acc};
        s_tuser  <= b.op;
        do @(posedge i_clk); while (!s_tready);
        beats_sent++;
    endtask

    // let the monitor queue the last beat sent, then wait until none is outstanding
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {imucal_pkg::REG_ONE_G, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_one_g(input logic [31:0] value);
        logic [31:0] unused;
        drain_results();
        apb_access(1'b1, value, unused);
    endtask

    task automatic read_back_one_g();
        logic [31:0] rdata;
        apb_access(1'b0, 32'h0, rdata);
        if (rdata !== {{(32 - G_W){1'b0}}, one_g})
            report_mismatch("one_g_counts readback", rdata, one_g);
    endtask

    function automatic t_imu_beat uniform_beat(logic op, imucal_pkg::t_raw v);
        t_imu_beat b;
        b.op = op;
        for (int i = 0; i < 3; i++) begin
            b.acc[i] = v;
            b.gyr[i] = v;
            b.mag[i] = v;
        end
        return b;
    endfunction

    function automatic t_imu_beat random_beat(logic op);
        t_imu_beat b;
        b.op = op;
        for (int i = 0; i < 3; i++) begin
            b.acc[i] = imucal_pkg::t_raw'($urandom);
            b.gyr[i] = imucal_pkg::t_raw'($urandom);
            b.mag[i] = imucal_pkg::t_raw'($urandom);
        end
        return b;
    endfunction

    function automatic t_imu_beat biased_beat(input int centre[9], input int spread);
        t_imu_beat b;
        int v[9];
        for (int k = 0; k < 9; k++) begin
            v[k] = centre[k] + $urandom_range(0, 2 * spread) - spread;
            if (v[k] > 32767) v[k] = 32767;
            if (v[k] < -32768) v[k] = -32768;
        end
        b.op = imucal_pkg::OP_SAMPLE;
        for (int i = 0; i < 3; i++) begin
            b.acc[i] = imucal_pkg::t_raw'(v[i]);
            b.gyr[i] = imucal_pkg::t_raw'(v[3 + i]);
            b.mag[i] = imucal_pkg::t_raw'(v[6 + i]);
        end
        return b;
    endfunction

    task automatic test_register_access();
        read_back_one_g();
        write_one_g(32'h0000_0000);
        read_back_one_g();
        write_one_g(32'hFFFF_FFFF);
        read_back_one_g();
        write_one_g(($urandom & 32'hFFFF_8000) | 32'h0000_1000);
        read_back_one_g();
    endtask

    task automatic test_directed_edges();
        src_idle = IDLE_SOME;
        snk_idle = IDLE_SOME;
        // no run yet: offsets are zero, state must not move
        send_beat(uniform_beat(imucal_pkg::OP_SAMPLE, 16'sh7FFF));
        send_beat(uniform_beat(imucal_pkg::OP_SAMPLE, 16'sh8000));
        send_beat(uniform_beat(imucal_pkg::OP_SAMPLE, 16'sh0000));
        send_beat(uniform_beat(imucal_pkg::OP_SAMPLE, 16'shFFFF));
        send_beat(uniform_beat(imucal_pkg::OP_START, 16'sh7FFF));
        // first sample seeds min and max, even when all negative
        send_beat(uniform_beat(imucal_pkg::OP_SAMPLE, 16'shFFFF));
        send_beat(uniform_beat(imucal_pkg::OP_SAMPLE, 16'sh8000));
        send_beat(uniform_beat(imucal_pkg::OP_SAMPLE, 16'sh7FFF));
        repeat (6) send_beat(random_beat(imucal_pkg::OP_SAMPLE));
        // restart part way through a run
        send_beat(uniform_beat(imucal_pkg::OP_START, 16'sh8000));
        send_beat(uniform_beat(imucal_pkg::OP_SAMPLE, 16'sh0001));
        repeat (4) send_beat(random_beat(imucal_pkg::OP_SAMPLE));
        send_beat(random_beat(imucal_pkg::OP_START));
        send_beat(random_beat(imucal_pkg::OP_SAMPLE));
    endtask

    // largest negative accel z bias, then the opposite extreme saturates
    task automatic test_extreme_calibration();
        t_imu_beat b;
        write_one_g(32'h0000_7FFF);
        read_back_one_g();
        src_idle = IDLE_NONE;
        snk_idle = IDLE_SOME;
        send_beat(uniform_beat(imucal_pkg::OP_START, 16'sh0000));
        for (int n = 0; n < CAL_N; n++) begin
            b = uniform_beat(imucal_pkg::OP_SAMPLE, 16'sh7FFF);
            b.acc[2] = 16'sh8000;
            for (int i = 0; i < 3; i++) b.gyr[i] = 16'sh8000;
            for (int i = 0; i < 3; i++) b.mag[i] = (n % 2 == 0) ? 16'sh7FFF : 16'sh8000;
            send_beat(b);
        end
        src_idle = IDLE_HEAVY;
        for (int n = 0; n < 6; n++) begin
            b = uniform_beat(imucal_pkg::OP_SAMPLE, 16'sh8000);
            b.acc[2] = 16'sh7FFF;
            for (int i = 0; i < 3; i++) b.gyr[i] = 16'sh7FFF;
            send_beat(b);
        end
    endtask

    function automatic logic [31:0] pick_one_g();
        logic [31:0] upper;
        upper = $urandom & 32'hFFFF_8000;
        case ($urandom_range(0, 3))
            0:       return upper;
            1:       return upper | 32'h0000_7FFF;
            2:       return upper | 32'h0000_1000;
            default: return upper | $urandom_range(0, 32767);
        endcase
    endfunction

    task automatic test_random_runs();
        int centre[9];
        int spread;
        int len;
        int pick;
        while (beats_sent < BEAT_TARGET) begin
            if ($urandom_range(0, 1) == 1) write_one_g(pick_one_g());
            src_idle = t_idle_mode'($urandom_range(0, 2));
            snk_idle = t_idle_mode'($urandom_range(0, 2));
            for (int k = 0; k < 9; k++) centre[k] = $urandom_range(0, 65535) - 32768;
            case ($urandom_range(0, 3))
                0:       spread = 0;
                1:       spread = 40;
                2:       spread = 2000;
                default: spread = 65535;
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                repeat ($urandom_range(5, 40)) send_beat(random_beat(imucal_pkg::OP_SAMPLE));
            end else begin
                len = (pick < 4) ? $urandom_range(1, CAL_N - 1) : CAL_N + $urandom_range(0, 20);
                send_beat(random_beat(imucal_pkg::OP_START));
                repeat (len) send_beat(biased_beat(centre, spread));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_access();
        test_directed_edges();
        test_extreme_calibration();
        test_random_runs();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (pending.size() != 0)
            report_mismatch("results still outstanding", 0, pending.size());
        $display("covered %0d beats, %0d results checked, %0d register writes",
                 beats_sent, results_seen, reg_writes);
        $display("%0d calibrations completed, %0d axis values saturated",
                 runs_completed, saturated_axes);
        if (mismatches == 0)
            $display("imu_offset_calibrator verification clean");
        else
            $display("imu_offset_calibrator verification failed");
        $finish;
    end

endmodule
